@@ rtl/kvrt_pkg.sv @@
// Shared types, codes and helpers of the key/value record tokenizer.
package kvrt_pkg;

   localparam int QueueDepth = 4;

   localparam logic [2:0] MinLen  = 3'd5;
   localparam logic [7:0] ChHash  = 8'h23;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChNl    = 8'h0A;
   localparam logic [7:0] ChNul   = 8'h00;
   localparam logic [7:0] DelimReset = 8'h0A;

   localparam logic [1:0] ROLE_IGNORED = 2'd0;
   localparam logic [1:0] ROLE_KEY     = 2'd1;
   localparam logic [1:0] ROLE_VALUE   = 2'd2;

   localparam logic [2:0] VERD_KEPT      = 3'd0;
   localparam logic [2:0] VERD_SHORT     = 3'd1;
   localparam logic [2:0] VERD_COMMENT   = 3'd2;
   localparam logic [2:0] VERD_BLANK     = 3'd3;
   localparam logic [2:0] VERD_END       = 3'd4;
   localparam logic [2:0] VERD_BAD_DELIM = 3'd5;

   localparam logic KIND_TAG    = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   // Verdict code and value-present flag of one record
   typedef struct packed {
      logic [2:0] code;
      logic       value_present;
   } verd_type;

   // Work for the back end: up to three results, always in the order
   // byte tag, record verdict, end or bad-delimiter notice.
   typedef struct packed {
      logic       tag_valid;
      logic [7:0] tag_byte;
      logic [1:0] role;
      logic       verd_valid;
      verd_type   verd;
      logic       note_valid;
      logic [2:0] note;
   } cmd_type;

   function automatic verd_type record_verdict(input logic [2:0] len,
                                               input logic       hash,
                                               input logic       graphic,
                                               input logic       vstart);
      verd_type v;
      v.value_present = 1'b0;
      if (len < MinLen) begin
         v.code = VERD_SHORT;
      end else if (hash) begin
         v.code = VERD_COMMENT;
      end else if (!graphic) begin
         v.code = VERD_BLANK;
      end else begin
         v.code          = VERD_KEPT;
         v.value_present = vstart;
      end
      return v;
   endfunction

endpackage

@@ rtl/kvrt_front.sv @@
// Front end: accepts bytes, tracks the record state and issues result work.
module kvrt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   input  logic             queue_ready,
   output logic             in_ready,
   output logic             push,
   output kvrt_pkg::cmd_type push_cmd
);
   import kvrt_pkg::*;

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_KEY   = 5'b00010,
      PH_GAP   = 5'b00100,
      PH_VALUE = 5'b01000,
      PH_TAIL  = 5'b10000
   } phase_type;

   logic [7:0] delim_ff;
   phase_type  phase_ff, phase_in, tphase;
   logic [2:0] len_ff, len_in, tlen;
   logic       graphic_ff, graphic_in, tgraphic;
   logic       hash_ff, hash_in, thash;
   logic       vstart_ff, vstart_in, tvstart;
   logic       stopped_ff, stopped_in;
   logic [1:0] trole;
   logic       accept, is_ws, is_brk, is_graphic, bad_delim;
   cmd_type    cmd;

   assign in_ready  = queue_ready;
   assign accept    = in_valid && queue_ready;
   assign is_ws     = (in_byte == ChSpace) || (in_byte == ChTab);
   assign is_brk    = is_ws || (in_byte == ChNl);
   assign is_graphic = (in_byte >= 8'h21) && (in_byte <= 8'h7E);
   assign bad_delim = (delim_ff == ChNul) || (delim_ff == ChSpace) || (delim_ff == ChTab);

   // Record state after tagging the incoming byte
   always_comb begin
      tphase   = phase_ff;
      tvstart  = vstart_ff;
      trole    = ROLE_IGNORED;
      tlen     = (len_ff < MinLen) ? len_ff + 3'd1 : len_ff;
      tgraphic = graphic_ff;
      thash    = hash_ff;
      if (is_graphic && !graphic_ff) begin
         tgraphic = 1'b1;
         thash    = (in_byte == ChHash);
      end
      unique case (phase_ff)
         PH_LEAD: begin
            if (!is_ws) begin
               if (in_byte == ChNl) begin
                  tphase = PH_GAP;
               end else begin
                  trole  = ROLE_KEY;
                  tphase = PH_KEY;
               end
            end
         end
         PH_KEY: begin
            if (is_brk) tphase = PH_GAP;
            else trole = ROLE_KEY;
         end
         PH_GAP: begin
            if (!is_ws) begin
               tvstart = 1'b1;
               if (in_byte == ChNl) begin
                  tphase = PH_TAIL;
               end else begin
                  trole  = ROLE_VALUE;
                  tphase = PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            if (is_brk) tphase = PH_TAIL;
            else trole = ROLE_VALUE;
         end
         PH_TAIL: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      graphic_in = graphic_ff;
      hash_in    = hash_ff;
      vstart_in  = vstart_ff;
      stopped_in = stopped_ff;
      cmd        = '0;
      if (accept) begin
         if (!stopped_ff) begin
            if (bad_delim) begin
               cmd.note_valid = 1'b1;
               cmd.note       = VERD_BAD_DELIM;
               stopped_in     = 1'b1;
            end else if ((in_byte == delim_ff) || (in_byte == ChNul)) begin
               if (len_ff == 3'd0) begin
                  cmd.note_valid = 1'b1;
                  cmd.note       = VERD_END;
                  stopped_in     = 1'b1;
               end else begin
                  cmd.verd_valid = 1'b1;
                  cmd.verd = record_verdict(len_ff, hash_ff, graphic_ff, vstart_ff);
                  phase_in   = PH_LEAD;
                  len_in     = 3'd0;
                  graphic_in = 1'b0;
                  hash_in    = 1'b0;
                  vstart_in  = 1'b0;
                  if ((in_byte == ChNul) || in_last) begin
                     cmd.note_valid = 1'b1;
                     cmd.note       = VERD_END;
                     stopped_in     = 1'b1;
                  end
               end
            end else begin
               cmd.tag_valid = 1'b1;
               cmd.tag_byte  = in_byte;
               cmd.role      = trole;
               phase_in   = tphase;
               len_in     = tlen;
               graphic_in = tgraphic;
               hash_in    = thash;
               vstart_in  = tvstart;
               if (in_last) begin
                  cmd.verd_valid = 1'b1;
                  cmd.verd       = record_verdict(tlen, thash, tgraphic, tvstart);
                  cmd.note_valid = 1'b1;
                  cmd.note       = VERD_END;
               end
            end
         end
         // rearm after the final byte of a buffer
         if (in_last) begin
            phase_in   = PH_LEAD;
            len_in     = 3'd0;
            graphic_in = 1'b0;
            hash_in    = 1'b0;
            vstart_in  = 1'b0;
            stopped_in = 1'b0;
         end
      end
   end

   assign push     = accept && !stopped_ff;
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff   <= DelimReset;
         phase_ff   <= PH_LEAD;
         len_ff     <= 3'd0;
         graphic_ff <= 1'b0;
         hash_ff    <= 1'b0;
         vstart_ff  <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         if (csr_wr_en) delim_ff <= csr_wr_data;
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         graphic_ff <= graphic_in;
         hash_ff    <= hash_in;
         vstart_ff  <= vstart_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

@@ rtl/kvrt_queue.sv @@
// Short work queue between the front and back ends.
module kvrt_queue #(
   parameter int DEPTH = kvrt_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kvrt_pkg::cmd_type push_cmd,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output kvrt_pkg::cmd_type pop_cmd
);
   import kvrt_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CntFull);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      if (push && !pop) count_in = count_ff + CntW'(1);
      else if (pop && !push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("queue count lost a write");

endmodule

@@ rtl/kvrt_back.sv @@
// Back end: plays each work entry out as one to three result transfers.
module kvrt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  kvrt_pkg::cmd_type pop_cmd,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_kind,
   output logic [7:0]        out_byte,
   output logic [1:0]        out_role,
   output logic [2:0]        out_verdict,
   output logic              out_vp,
   output logic              out_last
);
   import kvrt_pkg::*;

   cmd_type    cur_ff, cur_in;
   logic [2:0] mask_ff, mask_in;   // pending results: notice, verdict, tag
   logic [2:0] lowest, rest;
   logic       xfer;

   assign lowest    = mask_ff & (~mask_ff + 3'd1);
   assign rest      = mask_ff & ~lowest;
   assign out_valid = (mask_ff != 3'b000);
   assign out_last  = (rest == 3'b000);
   assign xfer      = out_valid && out_ready;
   assign pop       = pop_valid && (!out_valid || (xfer && out_last));

   always_comb begin
      out_kind    = KIND_NOTICE;
      out_byte    = 8'h00;
      out_role    = ROLE_IGNORED;
      out_verdict = cur_ff.note;
      out_vp      = 1'b0;
      if (lowest[0]) begin
         out_kind    = KIND_TAG;
         out_byte    = cur_ff.tag_byte;
         out_role    = cur_ff.role;
         out_verdict = VERD_KEPT;
      end else if (lowest[1]) begin
         out_verdict = cur_ff.verd.code;
         out_vp      = cur_ff.verd.value_present;
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      mask_in = mask_ff;
      if (xfer) mask_in = rest;
      if (pop) begin
         cur_in  = pop_cmd;
         mask_in = {pop_cmd.note_valid, pop_cmd.verd_valid, pop_cmd.tag_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mask_ff <= 3'b000;
      else mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

@@ rtl/key_value_record_tokenizer_top.sv @@
// Top level of the key/value record tokenizer.
//
// Usage:
//   req_*  : one text byte per transfer (tdata[7:0]); req_tlast marks the
//            final byte of a buffer, after which all record state rearms.
//   rsp_*  : result transfers; tuser is 0 for a byte tag, 1 for a record
//            verdict or end/bad-delimiter notice; tlast closes the run of
//            results caused by one input byte.
//   csr_*  : write of the delimiter register; write it only while idle.
// Path: the front end writes each taken byte's work into the queue, and the
// back end loads it from there into its output register.
// Throughput: one byte per cycle while rsp_tready is high and each byte
// gives at most one result; a byte giving two or three results holds the
// output until all are taken; the four-entry work queue absorbs short bursts.
// Stalls: while rsp_tready is low the output holds and the queue fills;
// req_tready drops only once the queue is full.
// Reset: synchronous, clears the queue, the record state and the output,
// and sets the delimiter to newline.
module key_value_record_tokenizer_top #(
   parameter int QUEUE_DEPTH = kvrt_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // delimiter
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] data_byte
   input  logic        req_tlast,     // buffer_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [7:0] tagged_byte, [9:8] byte_role,
                                      // [12:10] verdict, [13] value_present,
                                      // [15:14] zero
   output logic        rsp_tuser,     // result_kind
   output logic        rsp_tlast      // run_last
);
   import kvrt_pkg::*;

   logic       push, push_ready, pop, pop_valid;
   cmd_type    push_cmd, pop_cmd;
   logic [7:0] out_byte;
   logic [1:0] out_role;
   logic [2:0] out_verdict;
   logic       out_vp;

   // Classify each byte and advance the record state
   kvrt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .queue_ready (push_ready),
      .in_ready    (req_tready),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Decouple the two ends
   kvrt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   // Emit the results of each entry in order
   kvrt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_cmd     (pop_cmd),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_byte    (out_byte),
      .out_role    (out_role),
      .out_verdict (out_verdict),
      .out_vp      (out_vp),
      .out_last    (rsp_tlast)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = {2'b00, out_vp, out_verdict, out_role, out_byte};

endmodule

@@ test/key_value_record_tokenizer_top_tb.sv @@
// Self-checking testbench: streams text buffers into the record tokenizer and checks every result.
module key_value_record_tokenizer_top_tb;
   import kvrt_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int PrintCap   = 30;

   // Tokenizer phase within one record
   typedef enum logic [2:0] {
      PH_LEAD, PH_KEY, PH_GAP, PH_VALUE, PH_TAIL
   } token_phase_type;

   // One pending text byte and its end-of-buffer mark
   typedef struct packed {
      logic [7:0] octet;
      logic       fin;
   } text_item_type;

   // One expected result transfer
   typedef struct packed {
      logic       kind;
      logic [7:0] octet;
      logic [1:0] role;
      logic [2:0] verdict;
      logic       vp;
      logic       closes;
   } token_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // Predictor state, mirrors the block's record state and register
   token_phase_type phase      = PH_LEAD;
   logic [2:0]   rec_len       = 3'd0;
   logic         graphic_seen  = 1'b0;
   logic         hash_first    = 1'b0;
   logic         value_started = 1'b0;
   logic         halted        = 1'b0;
   logic [7:0]   delim         = DelimReset;

   text_item_type    pending[$];
   token_result_type results_due[$];
   text_item_type    next_item;
   token_result_type want;

   bit calm = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int cycles = 0;
   int mismatches = 0;
   int bytes_queued = 0;
   int bytes_sent = 0;
   int results_checked = 0;
   int settings_used = 1;
   int verdicts_seen[6] = '{default: 0};

   key_value_record_tokenizer_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic token_result_type make_result(input logic kind, input logic [7:0] octet,
                                                    input logic [1:0] role,
                                                    input logic [2:0] verdict, input logic vp);
      token_result_type r;
      r.kind    = kind;
      r.octet   = octet;
      r.role    = role;
      r.verdict = verdict;
      r.vp      = vp;
      r.closes  = 1'b0;
      return r;
   endfunction

   function automatic token_result_type notice(input logic [2:0] code);
      return make_result(KIND_NOTICE, 8'h00, ROLE_IGNORED, code, 1'b0);
   endfunction

   // Short beats comment, comment beats blank; only a kept record reports its value flag
   function automatic token_result_type judge_record();
      if (rec_len < MinLen) return notice(VERD_SHORT);
      if (hash_first) return notice(VERD_COMMENT);
      if (!graphic_seen) return notice(VERD_BLANK);
      return make_result(KIND_NOTICE, 8'h00, ROLE_IGNORED, VERD_KEPT, value_started);
   endfunction

   function automatic void clear_record();
      phase         = PH_LEAD;
      rec_len       = 3'd0;
      graphic_seen  = 1'b0;
      hash_first    = 1'b0;
      value_started = 1'b0;
   endfunction

   // Work out the results of one accepted byte and append them to the expected queue
   function automatic void predict_tokens(input logic [7:0] b, input logic fin);
      token_result_type run[3];
      int   n;
      logic ws;
      logic brk;
      logic [1:0] role;
      n    = 0;
      ws   = (b == ChSpace) || (b == ChTab);
      brk  = ws || (b == ChNl);
      role = ROLE_IGNORED;
      if (!halted) begin
         if (delim == ChNul || delim == ChSpace || delim == ChTab) begin
            run[n] = notice(VERD_BAD_DELIM);
            n++;
            halted = 1'b1;
         end else if (b == delim || b == ChNul) begin
            if (rec_len == 3'd0) begin
               // empty record: end notice only
               run[n] = notice(VERD_END);
               n++;
               halted = 1'b1;
            end else begin
               run[n] = judge_record();
               n++;
               clear_record();
               if (b == ChNul || fin) begin
                  run[n] = notice(VERD_END);
                  n++;
                  halted = 1'b1;
               end
            end
         end else begin
            if (rec_len < MinLen) rec_len++;
            if (b >= 8'h21 && b <= 8'h7E && !graphic_seen) begin
               graphic_seen = 1'b1;
               hash_first   = (b == ChHash);
            end
            case (phase)
               PH_LEAD: begin
                  // a newline here leaves the key empty
                  if (b == ChNl) phase = PH_GAP;
                  else if (!ws) begin
                     role  = ROLE_KEY;
                     phase = PH_KEY;
                  end
               end
               PH_KEY: begin
                  if (brk) phase = PH_GAP;
                  else role = ROLE_KEY;
               end
               PH_GAP: begin
                  if (!ws) begin
                     value_started = 1'b1;
                     if (b == ChNl) phase = PH_TAIL;
                     else begin
                        role  = ROLE_VALUE;
                        phase = PH_VALUE;
                     end
                  end
               end
               PH_VALUE: begin
                  if (brk) phase = PH_TAIL;
                  else role = ROLE_VALUE;
               end
               default: ;
            endcase
            run[n] = make_result(KIND_TAG, b, role, VERD_KEPT, 1'b0);
            n++;
            if (fin) begin
               run[n] = judge_record();
               n++;
               run[n] = notice(VERD_END);
               n++;
               halted = 1'b1;
            end
         end
      end
      // the final byte of a buffer always rearms
      if (fin) begin
         clear_record();
         halted = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
         run[i].closes = (i == n - 1);
         results_due.push_back(run[i]);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present pending bytes, predict on each transfer
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
         send_gap   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_tokens(req_tdata, req_tlast);
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               // idle now and for as long as the random send_gap counts down
               send_gap = $urandom_range(0, 9);
               req_tvalid <= 1'b0;
            end else begin
               next_item = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.octet;
               req_tlast  <= next_item.fin;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest expectation
   // ---------------------------------------------------------------------

   task automatic report(input string what, input int got, input int exp_val);
      mismatches++;
      if (mismatches <= PrintCap)
         $display("mismatch after %0d results, cycle %0d: %s got 0x%0h, wanted 0x%0h",
                  results_checked, cycles, what, got, exp_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report("result with nothing expected, tdata", rsp_tdata, 0);
            end else begin
               want = results_due.pop_front();
               if (rsp_tuser !== want.kind) report("result_kind", rsp_tuser, want.kind);
               if (rsp_tdata[7:0] !== want.octet)
                  report("tagged_byte", rsp_tdata[7:0], want.octet);
               if (rsp_tdata[9:8] !== want.role) report("byte_role", rsp_tdata[9:8], want.role);
               if (rsp_tdata[12:10] !== want.verdict)
                  report("verdict", rsp_tdata[12:10], want.verdict);
               if (rsp_tdata[13] !== want.vp) report("value_present", rsp_tdata[13], want.vp);
               if (rsp_tdata[15:14] !== 2'b00) report("tdata padding", rsp_tdata[15:14], 0);
               if (rsp_tlast !== want.closes) report("run_last", rsp_tlast, want.closes);
               if (want.kind == KIND_NOTICE) verdicts_seen[want.verdict]++;
               results_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("timeout: no progress after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] b, input logic fin);
      text_item_type t;
      t.octet = b;
      t.fin   = fin;
      pending.push_back(t);
      bytes_queued++;
   endfunction

   function automatic void queue_text(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], fin && (i == s.len() - 1));
   endfunction

   function automatic logic [7:0] pick_space();
      return ($urandom_range(0, 1) != 0) ? ChSpace : ChTab;
   endfunction

   function automatic logic [7:0] pick_graphic();
      logic [7:0] b;
      do b = 8'($urandom_range(8'h21, 8'h7E)); while (b == delim);
      return b;
   endfunction

   // any byte but NUL and the delimiter
   function automatic logic [7:0] pick_noise();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == delim);
      return b;
   endfunction

   // a byte that never counts as graphic
   function automatic logic [7:0] pick_dull();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == delim || (b >= 8'h21 && b <= 8'h7E));
      return b;
   endfunction

   // One buffer of one to four records, mostly well formed
   task automatic queue_buffer();
      logic [7:0] text_q[$];
      int records;
      int count;
      int shape;
      records = $urandom_range(1, 4);
      for (int r = 0; r < records; r++) begin
         shape = $urandom_range(0, 9);
         count = $urandom_range(0, 2);
         for (int i = 0; i < count; i++) text_q.push_back(pick_space());
         if (shape <= 4) begin
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++) text_q.push_back(pick_graphic());
            if ($urandom_range(0, 3) != 0) begin
               // usually blanks before the value, else a newline (which ends the record under a newline delimiter)
               if ($urandom_range(0, 5) == 0) text_q.push_back(ChNl);
               else begin
                  count = $urandom_range(1, 2);
                  for (int i = 0; i < count; i++) text_q.push_back(pick_space());
               end
               count = $urandom_range(0, 5);
               for (int i = 0; i < count; i++) text_q.push_back(pick_graphic());
               if ($urandom_range(0, 2) == 0) begin
                  text_q.push_back(pick_space());
                  count = $urandom_range(1, 3);
                  for (int i = 0; i < count; i++) text_q.push_back(pick_noise());
               end
            end
         end else if (shape == 5) begin
            text_q.push_back(ChHash);
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++) text_q.push_back(pick_graphic());
         end else if (shape == 6) begin
            count = $urandom_range(5, 7);
            for (int i = 0; i < count; i++) text_q.push_back(pick_dull());
         end else if (shape == 7) begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++) text_q.push_back(pick_graphic());
         end else if (shape == 8) begin
            count = $urandom_range(1, 8);
            for (int i = 0; i < count; i++) text_q.push_back(pick_noise());
         end
         // shape 9 adds nothing after the leading blanks: an empty record when there are none
         if (r < records - 1 || $urandom_range(0, 1) == 0) text_q.push_back(delim);
      end
      // now and then end early on NUL and trail some junk
      if ($urandom_range(0, 5) == 0) begin
         text_q.push_back(ChNul);
         count = $urandom_range(0, 3);
         for (int i = 0; i < count; i++) text_q.push_back(8'($urandom_range(0, 255)));
      end
      if (text_q.size() == 0) text_q.push_back(pick_noise());
      for (int i = 0; i < text_q.size(); i++) queue_byte(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic fill_random(input int budget);
      int goal;
      @(negedge clock);
      goal = bytes_queued + budget;
      while (bytes_queued < goal) queue_buffer();
   endtask

   function automatic bit busy();
      return pending.size() != 0 || req_tvalid || results_due.size() != 0;
   endfunction

   // Drain, let dropped bytes clear the pipeline, then write the register
   task automatic set_delimiter(input logic [7:0] value);
      @(negedge clock);
      while (busy()) @(negedge clock);
      repeat (8) @(negedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      delim = value;
      settings_used++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, newline delimiter from reset
      queue_text(" \ta\tb c\n", 1'b0);       // kept with value, tail ignored
      queue_text("#abcd", 1'b0);             // comment ended by NUL, then stop
      queue_byte(ChNul, 1'b0);
      queue_text("z", 1'b1);                 // dropped, rearm
      queue_byte(8'h80, 1'b0);               // blank: no graphic byte, top bit set
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_text(" \n", 1'b0);
      queue_text("ab", 1'b1);                // last byte tagged, then short and end
      queue_text("\n", 1'b1);                // empty record on the final byte
      queue_text("\nxy", 1'b1);              // empty record mid-buffer, rest dropped

      // printable delimiter: newline is now record text; it can leave the key empty and mark the value as started
      set_delimiter(8'h3B);
      @(negedge clock);
      queue_text("\n\nxyz;", 1'b0);
      fill_random(100);

      set_delimiter(8'hFF);
      fill_random(80);
      set_delimiter(8'h01);
      fill_random(70);

      // invalid delimiters: each buffer gives the bad-delimiter notice once
      set_delimiter(ChNul);
      fill_random(12);
      set_delimiter(ChSpace);
      fill_random(12);
      set_delimiter(ChTab);
      fill_random(12);

      // back to newline, no idling on either side
      set_delimiter(DelimReset);
      calm = 1'b1;
      fill_random(110);

      @(negedge clock);
      while (busy()) @(negedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d bytes under %0d delimiter settings, checked %0d results",
               bytes_sent, settings_used, results_checked);
      $display("verdicts: kept %0d, short %0d, comment %0d, blank %0d, end %0d, bad delim %0d",
               verdicts_seen[VERD_KEPT], verdicts_seen[VERD_SHORT],
               verdicts_seen[VERD_COMMENT], verdicts_seen[VERD_BLANK],
               verdicts_seen[VERD_END], verdicts_seen[VERD_BAD_DELIM]);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results still expected", mismatches, results_due.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
